// ----- rtl/lspp_pkg.sv -----
// ----------------------------------------------------------------------------
// Laser scan point projector package
// Shared types, register codes, fixed-point constants and series tables.
// ----------------------------------------------------------------------------
package lspp_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MUL_W     = 33;

	localparam int MAX_BEAMS_DEFAULT = 4096;

	localparam logic [23:0]        MIN_RANGE_RST = 24'd45875;
	localparam logic [23:0]        MAX_RANGE_RST = 24'd197263;
	localparam logic signed [19:0] MIN_ANGLE_RST = 20'sd0;
	localparam logic signed [19:0] MAX_ANGLE_RST = 20'sd524287;

	localparam logic signed [34:0] Q30_PI         = 35'sd3373259426;
	localparam logic signed [34:0] Q30_TWO_PI     = 35'sd6746518852;
	localparam logic signed [34:0] Q30_HALF_PI    = 35'sd1686629713;
	localparam logic signed [34:0] Q30_QUARTER_PI = 35'sd843314856;
	localparam logic signed [31:0] Q30_ONE        = 32'sd1073741824;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_SCAN   = 2'd1,
		OP_SAMPLE = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		REG_MIN_RANGE = 3'd0,
		REG_MAX_RANGE = 3'd1,
		REG_MIN_ANGLE = 3'd2,
		REG_MAX_ANGLE = 3'd3,
		REG_OFFSET_X  = 3'd4,
		REG_OFFSET_Y  = 3'd5,
		REG_OFFSET_Z  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [31:0] data;
	} cfg_item_t;

	typedef struct packed {
		logic [23:0]        min_range;
		logic [23:0]        max_range;
		logic signed [19:0] min_angle;
		logic signed [19:0] max_angle;
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic signed [31:0] offset_z;
	} cfg_regs_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [3:0]         matrix_index;
		logic signed [31:0] matrix_value;
		logic signed [19:0] start_angle;
		logic signed [19:0] angle_step;
		logic [23:0]        range;
		logic [15:0]        intensity;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [15:0]        echo_intensity;
		logic [23:0]        distance;
		logic [11:0]        beam_index;
		logic [31:0]        point_id;
		logic signed [31:0] view_x;
		logic signed [31:0] view_y;
		logic signed [31:0] view_z;
	} out_item_t;

	// series divisors: four sine terms, then five cosine terms
	function automatic logic [6:0] ser_div(input logic [3:0] i);
		logic [6:0] d;
		case (i)
			4'd0:    d = 7'd6;
			4'd1:    d = 7'd20;
			4'd2:    d = 7'd42;
			4'd3:    d = 7'd72;
			4'd4:    d = 7'd2;
			4'd5:    d = 7'd12;
			4'd6:    d = 7'd30;
			4'd7:    d = 7'd56;
			4'd8:    d = 7'd90;
			default: d = 7'd90;
		endcase
		return d;
	endfunction

	// floor(2^32 / divisor)
	function automatic logic [31:0] ser_recip(input logic [3:0] i);
		logic [31:0] r;
		case (i)
			4'd0:    r = 32'd715827882;
			4'd1:    r = 32'd214748364;
			4'd2:    r = 32'd102261126;
			4'd3:    r = 32'd59652323;
			4'd4:    r = 32'd2147483648;
			4'd5:    r = 32'd357913941;
			4'd6:    r = 32'd143165576;
			4'd7:    r = 32'd76695844;
			4'd8:    r = 32'd47721858;
			default: r = 32'd47721858;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/lspp_stream_if.sv -----
// ----------------------------------------------------------------------------
// Laser scan point projector stream interface
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface lspp_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/laser_scan_point_projector_core.sv -----
// ----------------------------------------------------------------------------
// Laser scan point projector
// Holds the configuration registers and runs the projection sequencer.
// ----------------------------------------------------------------------------
//  port    | dir | payload     | transaction
//  cfg     | in  | cfg_item_t  | one register write, always taken
//  items   | in  | in_item_t   | matrix load, scan start or range sample
//  points  | out | out_item_t  | one projected point
//
//  A matrix load is written on acceptance. A scan start runs the three pose
//  rows on the shared multiplier. An accepted sample runs the angle reduction,
//  nine series terms (multiply, reciprocal multiply, correction) and the three
//  pose rows. Gated or skipped samples leave the sequencer idle.
//  arst_n resets the configuration registers and sequencer control state; the pose matrix and viewpoint reset to zero.
//  A point waiting on points holds the sequencer at its end, not at entry.
module laser_scan_point_projector_core #(
	parameter int MAX_BEAMS = lspp_pkg::MAX_BEAMS_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	lspp_stream_if.sink   cfg,
	lspp_stream_if.sink   items,
	lspp_stream_if.source points
);
	import lspp_pkg::*;

	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.min_range <= MIN_RANGE_RST;
			regs_q.max_range <= MAX_RANGE_RST;
			regs_q.min_angle <= MIN_ANGLE_RST;
			regs_q.max_angle <= MAX_ANGLE_RST;
			regs_q.offset_x  <= '0;
			regs_q.offset_y  <= '0;
			regs_q.offset_z  <= '0;
		end else if (cfg.valid) begin
			case (cfg.payload.index)
				REG_MIN_RANGE: regs_q.min_range <= cfg.payload.data[23:0];
				REG_MAX_RANGE: regs_q.max_range <= cfg.payload.data[23:0];
				REG_MIN_ANGLE: regs_q.min_angle <= cfg.payload.data[19:0];
				REG_MAX_ANGLE: regs_q.max_angle <= cfg.payload.data[19:0];
				REG_OFFSET_X:  regs_q.offset_x  <= cfg.payload.data;
				REG_OFFSET_Y:  regs_q.offset_y  <= cfg.payload.data;
				REG_OFFSET_Z:  regs_q.offset_z  <= cfg.payload.data;
				default:       regs_q <= regs_q;
			endcase
		end
	end

	lspp_seq #(
		.MAX_BEAMS (MAX_BEAMS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_regs (regs_q),
		.items    (items),
		.points   (points)
	);
endmodule

// ----- rtl/lspp_mul.sv -----
// ----------------------------------------------------------------------------
// Laser scan point projector multiplier
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module lspp_mul (
	input  logic                                clk,
	input  logic signed [lspp_pkg::MUL_W-1:0]   a,
	input  logic signed [lspp_pkg::MUL_W-1:0]   b,
	output logic signed [2*lspp_pkg::MUL_W-1:0] p
);
	import lspp_pkg::*;

	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule

// ----- rtl/lspp_seq.sv -----
// ----------------------------------------------------------------------------
// Laser scan point projector sequencer
// Runs scan starts and accepted samples through the shared multiplier: pose
// rows, sine and cosine series and the point transform, after angle reduction.
// ----------------------------------------------------------------------------
module lspp_seq #(
	parameter int MAX_BEAMS = lspp_pkg::MAX_BEAMS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lspp_pkg::cfg_regs_t  cfg_regs,
	lspp_stream_if.sink          items,
	lspp_stream_if.source        points
);
	import lspp_pkg::*;

	localparam int CW = $clog2(MAX_BEAMS);

	typedef enum logic [4:0] {
		ST_IDLE, ST_ROW, ST_RED_MOD, ST_RED_PI, ST_RED_HALF, ST_RED_QTR,
		ST_SQ, ST_SQ_TAKE, ST_SER_MUL, ST_SER_V, ST_SER_REC, ST_SER_CORR,
		ST_APPLY, ST_PT_C, ST_PT_CT, ST_PT_ST, ST_EMIT
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
		logic signed [31:0] r;
		if (v > 52'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -52'sd2147483648)
			r = 32'sh80000000;
		else
			r = 32'(v);
		return r;
	endfunction

	state_t state_q;

	logic signed [31:0] mat_q [12];
	logic signed [31:0] view_q [3];
	logic signed [31:0] vec_q [3];
	logic signed [31:0] pt_q [3];
	logic signed [19:0] angle_q, step_q;
	logic [CW-1:0]      cnt_q;
	logic [31:0]        next_id_q;
	logic               skip_q;

	logic [23:0]        d_q;
	logic [15:0]        inten_q;
	logic [11:0]        bidx_q;

	logic               vp_mode_q, same_q;
	logic [1:0]         row_q;
	logic [2:0]         j_q;
	logic signed [65:0] acc_q;

	logic signed [34:0] r_q;
	logic               negc_q, fold_hi_q, fold_lo_q;
	logic signed [31:0] x_q, x2_q, term_q, v_q, sin_q, cos_q, s_q, c_q;
	logic [3:0]         iter_q;

	logic               out_valid_q;
	out_item_t          out_q;

	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*MUL_W-1:0] mul_q;

	lspp_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_q)
	);

	// matrix entry of current row: column three once the products are in
	logic [1:0]         col;
	logic signed [31:0] mat_rd, vec_rd;
	assign col    = (j_q == 3'd4) ? 2'd3 : j_q[1:0];
	assign mat_rd = mat_q[{row_q, col}];

	always_comb begin
		case (j_q[1:0])
			2'd0:    vec_rd = vec_q[0];
			2'd1:    vec_rd = vec_q[1];
			2'd2:    vec_rd = vec_q[2];
			default: vec_rd = vec_q[0];
		endcase
	end

	// series division by reciprocal with one correction
	logic [31:0]        av, q0, q;
	logic [6:0]         div;
	logic [39:0]        rem;
	logic signed [31:0] t;
	assign av  = v_q[31] ? 32'(-v_q) : 32'(v_q);
	assign div = ser_div(iter_q);
	assign q0  = mul_q[63:32];
	assign rem = {8'd0, av} - (40'(q0) * 40'(div));
	assign q   = q0 + 32'(rem >= 40'(div));
	assign t   = v_q[31] ? signed'(q) : -signed'(q);

	logic signed [51:0] row_sum;
	logic signed [31:0] row_res;
	assign row_sum = 52'(acc_q >>> FRAC_BITS) + 52'(mat_rd);
	assign row_res = sat32(row_sum);

	logic signed [51:0] dc_r;
	assign dc_r = 52'((mul_q + 66'sd536870912) >>> 30);

	logic [CW:0] cnt_inc;
	assign cnt_inc = {1'b0, cnt_q} + 1'b1;

	logic accept;
	assign items.ready = (state_q == ST_IDLE);
	assign accept      = items.valid && items.ready;
	assign points.valid   = out_valid_q;
	assign points.payload = out_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_ROW: begin
				mul_a = MUL_W'(mat_rd);
				mul_b = MUL_W'(vec_rd);
			end
			ST_SQ: begin
				mul_a = MUL_W'(x_q);
				mul_b = MUL_W'(x_q);
			end
			ST_SER_MUL: begin
				mul_a = MUL_W'(term_q);
				mul_b = MUL_W'(x2_q);
			end
			ST_SER_REC: begin
				mul_a = {1'b0, av};
				mul_b = {1'b0, ser_recip(iter_q)};
			end
			ST_PT_C: begin
				mul_a = {9'd0, d_q};
				mul_b = MUL_W'(c_q);
			end
			ST_PT_CT: begin
				mul_a = {9'd0, d_q};
				mul_b = MUL_W'(s_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			for (int i = 0; i < 12; i++) mat_q[i] <= '0;
			for (int i = 0; i < 3; i++) view_q[i] <= '0;
			angle_q     <= '0;
			step_q      <= '0;
			cnt_q       <= '0;
			next_id_q   <= 32'd1;
			skip_q      <= 1'b0;
			out_valid_q <= 1'b0;
			row_q       <= '0;
			j_q         <= '0;
			iter_q      <= '0;
			vp_mode_q   <= 1'b0;
			same_q      <= 1'b0;
		end else begin
			if (out_valid_q && points.ready && state_q != ST_EMIT)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (items.payload.op)
							OP_LOAD: begin
								if (items.payload.matrix_index < 4'd12)
									mat_q[items.payload.matrix_index] <=
										items.payload.matrix_value;
							end
							OP_SCAN: begin
								angle_q   <= items.payload.start_angle;
								step_q    <= items.payload.angle_step;
								cnt_q     <= '0;
								vec_q[0]  <= cfg_regs.offset_x;
								vec_q[1]  <= cfg_regs.offset_y;
								vec_q[2]  <= cfg_regs.offset_z;
								row_q     <= '0;
								j_q       <= '0;
								same_q    <= 1'b1;
								vp_mode_q <= 1'b1;
								state_q   <= ST_ROW;
							end
							OP_SAMPLE: begin
								if (!skip_q) begin
									d_q     <= items.payload.range;
									inten_q <= items.payload.intensity;
									bidx_q  <= 12'(cnt_q);
									angle_q <= angle_q + step_q;
									cnt_q   <= (cnt_inc >= (CW+1)'(MAX_BEAMS)) ?
										'0 : cnt_inc[CW-1:0];
									r_q     <= {angle_q[19], angle_q, 14'd0};
									if (items.payload.range >= cfg_regs.min_range &&
										items.payload.range <= cfg_regs.max_range &&
										angle_q >= cfg_regs.min_angle &&
										angle_q <= cfg_regs.max_angle)
										state_q <= ST_RED_MOD;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_ROW: begin
					j_q <= (j_q == 3'd4) ? 3'd0 : j_q + 3'd1;
					case (j_q)
						3'd0: acc_q <= acc_q;
						3'd1: acc_q <= mul_q + 66'sd32768;
						3'd2: acc_q <= acc_q + mul_q;
						3'd3: acc_q <= acc_q + mul_q;
						default: begin
							if (vp_mode_q) begin
								same_q        <= same_q && (row_res == view_q[row_q]);
								view_q[row_q] <= row_res;
							end else begin
								pt_q[row_q] <= row_res;
							end
							if (row_q == 2'd2) begin
								if (vp_mode_q) begin
									skip_q  <= same_q && (row_res == view_q[row_q]);
									state_q <= ST_IDLE;
								end else begin
									state_q <= ST_EMIT;
								end
							end else begin
								row_q <= row_q + 2'd1;
							end
						end
					endcase
				end
				ST_RED_MOD: begin
					if (r_q >= Q30_TWO_PI)
						r_q <= r_q - Q30_TWO_PI;
					else if (r_q <= -Q30_TWO_PI)
						r_q <= r_q + Q30_TWO_PI;
					state_q <= ST_RED_PI;
				end
				ST_RED_PI: begin
					if (r_q > Q30_PI)
						r_q <= r_q - Q30_TWO_PI;
					else if (r_q < -Q30_PI)
						r_q <= r_q + Q30_TWO_PI;
					state_q <= ST_RED_HALF;
				end
				ST_RED_HALF: begin
					if (r_q > Q30_HALF_PI) begin
						r_q    <= Q30_PI - r_q;
						negc_q <= 1'b1;
					end else if (r_q < -Q30_HALF_PI) begin
						r_q    <= -Q30_PI - r_q;
						negc_q <= 1'b1;
					end else begin
						negc_q <= 1'b0;
					end
					state_q <= ST_RED_QTR;
				end
				ST_RED_QTR: begin
					if (r_q > Q30_QUARTER_PI) begin
						x_q       <= 32'(Q30_HALF_PI - r_q);
						fold_hi_q <= 1'b1;
						fold_lo_q <= 1'b0;
					end else if (r_q < -Q30_QUARTER_PI) begin
						x_q       <= 32'(Q30_HALF_PI + r_q);
						fold_hi_q <= 1'b0;
						fold_lo_q <= 1'b1;
					end else begin
						x_q       <= 32'(r_q);
						fold_hi_q <= 1'b0;
						fold_lo_q <= 1'b0;
					end
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					state_q <= ST_SQ_TAKE;
				end
				ST_SQ_TAKE: begin
					x2_q    <= 32'(mul_q >>> 30);
					term_q  <= x_q;
					sin_q   <= x_q;
					cos_q   <= Q30_ONE;
					iter_q  <= '0;
					state_q <= ST_SER_MUL;
				end
				ST_SER_MUL: begin
					state_q <= ST_SER_V;
				end
				ST_SER_V: begin
					v_q     <= 32'(mul_q >>> 30);
					state_q <= ST_SER_REC;
				end
				ST_SER_REC: begin
					state_q <= ST_SER_CORR;
				end
				ST_SER_CORR: begin
					if (iter_q < 4'd4)
						sin_q <= sin_q + t;
					else
						cos_q <= cos_q + t;
					// cosine series restarts from one
					term_q  <= (iter_q == 4'd3) ? Q30_ONE : t;
					iter_q  <= iter_q + 4'd1;
					state_q <= (iter_q == 4'd8) ? ST_APPLY : ST_SER_MUL;
				end
				ST_APPLY: begin
					if (fold_hi_q) begin
						s_q <= cos_q;
						c_q <= negc_q ? -sin_q : sin_q;
					end else if (fold_lo_q) begin
						s_q <= -cos_q;
						c_q <= negc_q ? -sin_q : sin_q;
					end else begin
						s_q <= sin_q;
						c_q <= negc_q ? -cos_q : cos_q;
					end
					state_q <= ST_PT_C;
				end
				ST_PT_C: begin
					state_q <= ST_PT_CT;
				end
				ST_PT_CT: begin
					vec_q[1] <= sat32(52'(cfg_regs.offset_y) - dc_r);
					state_q  <= ST_PT_ST;
				end
				ST_PT_ST: begin
					vec_q[0]  <= cfg_regs.offset_x;
					vec_q[2]  <= sat32(52'(cfg_regs.offset_z) + dc_r);
					row_q     <= '0;
					j_q       <= '0;
					vp_mode_q <= 1'b0;
					state_q   <= ST_ROW;
				end
				ST_EMIT: begin
					// hold until the output register is free
					if (!out_valid_q || points.ready) begin
						out_q.point_x        <= pt_q[0];
						out_q.point_y        <= pt_q[1];
						out_q.point_z        <= pt_q[2];
						out_q.echo_intensity <= inten_q;
						out_q.distance       <= d_q;
						out_q.beam_index     <= bidx_q;
						out_q.point_id       <= next_id_q;
						out_q.view_x         <= view_q[0];
						out_q.view_y         <= view_q[1];
						out_q.view_z         <= view_q[2];
						out_valid_q          <= 1'b1;
						next_id_q            <= next_id_q + 32'd1;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

// ----- dv/tb_laser_scan_point_projector_core.sv -----
// ----------------------------------------------------------------------------
// Laser scan point projector testbench
// Drives pose loads, scan starts and range samples with random idling and
// back-pressure, predicts every projected point in fixed point and checks
// each point transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_laser_scan_point_projector_core;
	import lspp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lspp_stream_if #(.T(cfg_item_t)) cfg_ch ();
	lspp_stream_if #(.T(in_item_t))  item_ch ();
	lspp_stream_if #(.T(out_item_t)) point_ch ();

	laser_scan_point_projector_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch.sink),
		.items  (item_ch.sink),
		.points (point_ch.source)
	);

	always #6 clk = ~clk;

	in_item_t  pending_items[$];
	out_item_t expected_points[$];
	int        err_count = 0;
	bit        calm = 1'b0;
	int        hold_req = 0;
	int        hold_left = 0;
	bit        item_taken = 1'b0;

	// predictor state
	logic [23:0]        p_min_range, p_max_range;
	logic signed [19:0] p_min_angle, p_max_angle;
	longint             p_off[3];
	longint             pose[12];
	longint             view[3];
	logic signed [19:0] angle_acc, angle_inc;
	int unsigned        beam_cnt;
	logic [31:0]        id_next;
	bit                 skipping;

	function automatic longint sat32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint pose_row(int r, longint v0, longint v1, longint v2);
		longint v[3];
		longint hi, lo, p, h;
		v[0] = v0; v[1] = v1; v[2] = v2;
		hi = 0; lo = 0;
		for (int i = 0; i < 3; i++) begin
			p = pose[r*4+i] * v[i];
			h = p >>> FRAC_BITS;
			hi += h;
			lo += p - h * (64'sd1 << FRAC_BITS);
		end
		lo += 64'sd1 << (FRAC_BITS - 1);
		return sat32(hi + (lo >>> FRAC_BITS) + pose[r*4+3]);
	endfunction

	function automatic longint taylor_sin(longint x);
		longint x2, term, s;
		x2 = (x * x) >>> 30;
		term = x; s = x;
		for (longint k = 1; k <= 4; k++) begin
			term = -((term * x2) >>> 30) / ((2*k) * (2*k+1));
			s += term;
		end
		return s;
	endfunction

	function automatic longint taylor_cos(longint x);
		longint x2, term, c;
		x2 = (x * x) >>> 30;
		term = longint'(Q30_ONE); c = term;
		for (longint k = 1; k <= 5; k++) begin
			term = -((term * x2) >>> 30) / ((2*k-1) * (2*k));
			c += term;
		end
		return c;
	endfunction

	task automatic beam_trig(input longint ang, output longint s, output longint c);
		longint r, cv;
		bit flip;
		longint pi_q, two_pi, half_pi, qtr_pi;
		pi_q = longint'(Q30_PI); two_pi = longint'(Q30_TWO_PI);
		half_pi = longint'(Q30_HALF_PI); qtr_pi = longint'(Q30_QUARTER_PI);
		flip = 1'b0;
		r = (ang * (64'sd1 << (30 - FRAC_BITS))) % two_pi;
		if (r > pi_q) r -= two_pi;
		if (r < -pi_q) r += two_pi;
		if (r > half_pi) begin
			r = pi_q - r; flip = 1'b1;
		end else if (r < -half_pi) begin
			r = -pi_q - r; flip = 1'b1;
		end
		if (r > qtr_pi) begin
			s = taylor_cos(half_pi - r); cv = taylor_sin(half_pi - r);
		end else if (r < -qtr_pi) begin
			s = -taylor_cos(half_pi + r); cv = taylor_sin(half_pi + r);
		end else begin
			s = taylor_sin(r); cv = taylor_cos(r);
		end
		c = flip ? -cv : cv;
	endtask

	task automatic project_item(input in_item_t it);
		longint nv[3], d, a, s, c, py, pz;
		out_item_t pt;
		case (it.op)
			OP_LOAD: begin
				if (it.matrix_index < 12) pose[it.matrix_index] = longint'(it.matrix_value);
			end
			OP_SCAN: begin
				angle_acc = it.start_angle;
				angle_inc = it.angle_step;
				beam_cnt = 0;
				for (int r = 0; r < 3; r++) nv[r] = pose_row(r, p_off[0], p_off[1], p_off[2]);
				skipping = (nv[0] == view[0] && nv[1] == view[1] && nv[2] == view[2]);
				for (int r = 0; r < 3; r++) view[r] = nv[r];
			end
			OP_SAMPLE: begin
				if (!skipping) begin
					d = longint'(it.range);
					a = longint'(angle_acc);
					pt.beam_index = beam_cnt[11:0];
					angle_acc = angle_acc + angle_inc;
					beam_cnt = (beam_cnt + 1 >= MAX_BEAMS_DEFAULT) ? 0 : beam_cnt + 1;
					if (it.range >= p_min_range && it.range <= p_max_range &&
					    a >= longint'(p_min_angle) && a <= longint'(p_max_angle)) begin
						beam_trig(a, s, c);
						py = sat32(p_off[1] - ((d * c + (64'sd1 << 29)) >>> 30));
						pz = sat32(p_off[2] + ((d * s + (64'sd1 << 29)) >>> 30));
						pt.point_x = 32'(pose_row(0, p_off[0], py, pz));
						pt.point_y = 32'(pose_row(1, p_off[0], py, pz));
						pt.point_z = 32'(pose_row(2, p_off[0], py, pz));
						pt.echo_intensity = it.intensity;
						pt.distance = it.range;
						pt.point_id = id_next;
						pt.view_x = view[0][31:0];
						pt.view_y = view[1][31:0];
						pt.view_z = view[2][31:0];
						id_next = id_next + 32'd1;
						expected_points = {expected_points, pt};
					end
				end
			end
			default: ;
		endcase
	endtask

	// monitor: check points, predict accepted items, track register writes
	always @(posedge clk) begin
		out_item_t want, got;
		if (point_ch.valid && point_ch.ready) begin
			got = point_ch.payload;
			if (expected_points.size() == 0) begin
				$error("point with no prediction waiting: id %0d", got.point_id);
				err_count++;
			end else begin
				want = expected_points.pop_front();
				if (got.point_x !== want.point_x) begin
					$error("point_x expected %0d got %0d", want.point_x, got.point_x); err_count++;
				end
				if (got.point_y !== want.point_y) begin
					$error("point_y expected %0d got %0d", want.point_y, got.point_y); err_count++;
				end
				if (got.point_z !== want.point_z) begin
					$error("point_z expected %0d got %0d", want.point_z, got.point_z); err_count++;
				end
				if (got.echo_intensity !== want.echo_intensity) begin
					$error("echo_intensity expected %0d got %0d", want.echo_intensity,
						got.echo_intensity); err_count++;
				end
				if (got.distance !== want.distance) begin
					$error("distance expected %0d got %0d", want.distance, got.distance);
					err_count++;
				end
				if (got.beam_index !== want.beam_index) begin
					$error("beam_index expected %0d got %0d", want.beam_index, got.beam_index);
					err_count++;
				end
				if (got.point_id !== want.point_id) begin
					$error("point_id expected %0d got %0d", want.point_id, got.point_id);
					err_count++;
				end
				if (got.view_x !== want.view_x) begin
					$error("view_x expected %0d got %0d", want.view_x, got.view_x); err_count++;
				end
				if (got.view_y !== want.view_y) begin
					$error("view_y expected %0d got %0d", want.view_y, got.view_y); err_count++;
				end
				if (got.view_z !== want.view_z) begin
					$error("view_z expected %0d got %0d", want.view_z, got.view_z); err_count++;
				end
			end
		end
		if (item_ch.valid && item_ch.ready) begin
			item_taken = 1'b1;
			project_item(item_ch.payload);
		end
		if (cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_idx_t'(cfg_ch.payload.index))
				REG_MIN_RANGE: p_min_range = cfg_ch.payload.data[23:0];
				REG_MAX_RANGE: p_max_range = cfg_ch.payload.data[23:0];
				REG_MIN_ANGLE: p_min_angle = cfg_ch.payload.data[19:0];
				REG_MAX_ANGLE: p_max_angle = cfg_ch.payload.data[19:0];
				REG_OFFSET_X:  p_off[0] = longint'(signed'(cfg_ch.payload.data));
				REG_OFFSET_Y:  p_off[1] = longint'(signed'(cfg_ch.payload.data));
				REG_OFFSET_Z:  p_off[2] = longint'(signed'(cfg_ch.payload.data));
				default: ;
			endcase
		end
	end

	// item driver
	always @(negedge clk) begin
		if (!item_ch.valid || item_taken) begin
			if (arst_n && pending_items.size() > 0 && (calm || $urandom_range(99) >= 8)) begin
				item_ch.valid <= 1'b1;
				item_ch.payload <= pending_items.pop_front();
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
		item_taken = 1'b0;
	end

	// point receiver, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			point_ch.ready <= 1'b0;
		end else begin
			point_ch.ready <= calm || ($urandom_range(99) >= 8);
		end
	end

	task automatic push_load(input int idx, input int val);
		in_item_t it;
		it = '0;
		it.op = OP_LOAD;
		it.matrix_index = idx[3:0];
		it.matrix_value = val;
		pending_items = {pending_items, it};
	endtask

	task automatic push_scan(input int sa, input int st);
		in_item_t it;
		it = '0;
		it.op = OP_SCAN;
		it.start_angle = sa[19:0];
		it.angle_step = st[19:0];
		it.matrix_value = $urandom;
		pending_items = {pending_items, it};
	endtask

	task automatic push_sample(input int unsigned rng, input int unsigned inten);
		in_item_t it;
		it = '0;
		it.op = OP_SAMPLE;
		it.range = rng[23:0];
		it.intensity = inten[15:0];
		pending_items = {pending_items, it};
	endtask

	function automatic int srand(int lim);
		return int'($urandom_range(0, 2*lim)) - lim;
	endfunction

	task automatic push_pose();
		for (int i = 0; i < 12; i++) begin
			if ($urandom_range(19) == 0) push_load(i, $urandom);
			else if (i % 4 == 3) push_load(i, srand(1 << 22));
			else push_load(i, srand(1 << 17));
		end
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || item_ch.valid || expected_points.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.payload <= '{index: idx, data: val};
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic write_all(input logic [23:0] rmin, input logic [23:0] rmax,
	                         input logic [19:0] amin, input logic [19:0] amax,
	                         input logic [31:0] ox, input logic [31:0] oy,
	                         input logic [31:0] oz);
		write_reg(REG_MIN_RANGE, {8'($urandom_range(255)), rmin});
		write_reg(REG_MAX_RANGE, {8'($urandom_range(255)), rmax});
		write_reg(REG_MIN_ANGLE, {12'($urandom_range(4095)), amin});
		write_reg(REG_MAX_ANGLE, {12'($urandom_range(4095)), amax});
		write_reg(REG_OFFSET_X, ox);
		write_reg(REG_OFFSET_Y, oy);
		write_reg(REG_OFFSET_Z, oz);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// well-formed scans with random content and some noise
	task automatic random_scans(input int n_items, input int unsigned rmin,
	                            input int unsigned rmax);
		int target;
		in_item_t it;
		target = pending_items.size() + n_items;
		while (pending_items.size() < target) begin
			if ($urandom_range(3) != 0) push_pose();
			else push_load($urandom_range(11), srand(1 << 22));
			push_scan(srand(524287), $urandom_range(3) == 0 ? srand(524287) : srand(8000));
			repeat ($urandom_range(4, 30)) begin
				case ($urandom_range(19))
					0: begin
						it = '0;
						it.op = 2'd3;
						it.range = 24'($urandom);
						pending_items = {pending_items, it};
					end
					1: push_load($urandom_range(15), $urandom);
					2: push_sample($urandom, $urandom);
					default: push_sample($urandom_range(rmax, rmin), $urandom);
				endcase
			end
			// repeated scan start with no pose change is skipped
			if ($urandom_range(9) == 0) begin
				push_scan(srand(524287), srand(8000));
				repeat (3) push_sample($urandom_range(rmax, rmin), $urandom);
			end
		end
	endtask

	initial begin
		cfg_ch.valid = 1'b0;
		cfg_ch.payload = '0;
		item_ch.valid = 1'b0;
		item_ch.payload = '0;
		point_ch.ready = 1'b0;
		p_min_range = MIN_RANGE_RST;
		p_max_range = MAX_RANGE_RST;
		p_min_angle = MIN_ANGLE_RST;
		p_max_angle = MAX_ANGLE_RST;
		for (int i = 0; i < 3; i++) begin
			p_off[i] = 0; view[i] = 0;
		end
		for (int i = 0; i < 12; i++) pose[i] = 0;
		angle_acc = '0; angle_inc = '0; beam_cnt = 0; id_next = 32'd1; skipping = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, reset register values
		push_sample(MIN_RANGE_RST, 16'hffff);
		push_sample(MAX_RANGE_RST, 0);
		push_scan(0, 1000);
		push_sample(100000, 5);
		push_load(12, 32'h7fffffff);
		push_load(15, 32'h80000000);
		begin
			in_item_t it;
			it = '1;
			it.op = 2'd3;
			pending_items = {pending_items, it};
		end
		push_load(0, 32'h00010000); push_load(5, 32'h00010000);
		push_load(10, 32'h00010000); push_load(3, 32'h00020000);
		push_scan(20'h7ffff, 20'h80000);
		push_sample(MIN_RANGE_RST, 0);
		push_sample(MAX_RANGE_RST, 16'hffff);
		push_sample(MIN_RANGE_RST - 1, 1);
		push_sample(MAX_RANGE_RST + 1, 2);
		push_sample(0, 3);
		push_sample(24'hffffff, 4);
		push_load(7, 32'hfffe0000);
		push_sample(150000, 6);
		drain();

		// full gates, extreme offsets to force saturation
		write_all(24'd0, 24'hffffff, 20'h80000, 20'h7ffff,
			32'h7fffffff, 32'h80000000, 32'h7fffffff);
		push_pose();
		push_load(0, 32'h7fffffff);
		push_load(6, 32'h80000000);
		push_scan(20'h80000, 20'h7ffff);
		repeat (8) push_sample($urandom, $urandom);
		push_sample(24'hffffff, 0);
		push_sample(0, 16'hffff);
		drain();

		// wide gates, moderate offsets, calm stretch
		calm = 1'b1;
		write_all(24'd0, 24'hffffff, 20'h80000, 20'h7ffff,
			srand(1 << 20), srand(1 << 20), srand(1 << 20));
		random_scans(300, 24'hffffff, 0);
		drain();
		calm = 1'b0;

		// long scan of mostly gated samples
		write_all(24'd100, 24'd200, 20'h80000, 20'h7ffff, 32'h1000, 32'h2000, 32'h3000);
		push_pose();
		push_scan(0, 37);
		for (int i = 0; i < 200; i++)
			push_sample((i % 16 == 0 || i > 190) ? 150 : 5000, i);
		drain();

		// default-like gates, receiver holds off while the sender keeps going
		write_all(24'd45875, 24'd197263, 20'd0, 20'h7ffff,
			srand(1 << 18), srand(1 << 18), srand(1 << 18));
		hold_req = 3000;
		random_scans(400, 197263, 45875);
		drain();

		// narrow equal range gate and a narrow angle window
		write_all(24'd65536, 24'd65536, 20'hf0000, 20'h10000, 0, srand(1 << 16), 0);
		random_scans(250, 65536, 65536);
		drain();

		// random settings
		repeat (3) begin
			int unsigned a, b;
			a = $urandom_range(1 << 20);
			b = a + $urandom_range(1 << 22);
			write_all(24'(a), 24'(b), 20'(srand(200000)),
				20'(20'h7ffff - $urandom_range(200000)),
				srand(1 << 22), srand(1 << 22), srand(1 << 22));
			random_scans(150, b, a);
			drain();
		end

		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#30ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- laser_scan_point_projector_core.f -----
rtl/lspp_pkg.sv
rtl/lspp_stream_if.sv
rtl/lspp_mul.sv
rtl/lspp_seq.sv
rtl/laser_scan_point_projector_core.sv
dv/tb_laser_scan_point_projector_core.sv
